/* hw/rtl/bpls_pkg.sv */
package bpls_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int COLOUR_W = 48;
	localparam int DPOWER_W = 32;
	localparam int SHINE_W = 16;
	localparam int SUM_W = 40;
	localparam int VEC_W = 34;
	localparam int MAG_W = 30;
	localparam int RAD_W = 62;
	localparam int ROOT_W = 31;
	localparam int DEN_W = 34;
	localparam int QUO_W = 32;
	localparam int Q30_W = 31;
	localparam int MUL_W = 33;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [DPOWER_W-1:0] DPOWER_RST = 32'd65536;
	localparam logic [SHINE_W-1:0] SHINE_RST = 16'd8192;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMBIENT  = 3'd0,
		REG_DIFFUSE  = 3'd1,
		REG_SPECULAR = 3'd2,
		REG_DPOWER   = 3'd3,
		REG_SHINE    = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_SURFACE = 1'b0,
		KIND_LIGHT   = 1'b1
	} kind_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] ambient;
		logic [COLOUR_W-1:0] diffuse;
		logic [COLOUR_W-1:0] specular;
		logic [DPOWER_W-1:0] dpower;
		logic [SHINE_W-1:0]  shine;
	} cfg_t;

	typedef struct packed {
		kind_t                    kind;
		logic                     last;
		logic [2:0][COORD_W-1:0]  ray;
		logic [2:0][COORD_W-1:0]  point;
		logic [2:0][COORD_W-1:0]  normal;
	} item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_st_t;

	typedef enum logic [5:0] {
		S_IDLE, S_UMAG, S_USQ, S_UACC, S_USQRT_GO, S_USQRT, S_UDIV_GO, S_UDIV,
		S_UDONE, S_DOTM, S_DOTA, S_DCLAMP, S_HVEC, S_POW0, S_PNORM, S_PSQM,
		S_PSQA, S_PTM, S_PTA, S_PEXM, S_PEXA, S_PFIN, S_RDGO, S_RDW, S_RSGO,
		S_RSW, S_TM1, S_TM2, S_TM3, S_TM4, S_TM5, S_SAT, S_EMIT
	} state_t;

	// integer square root, elaboration use only
	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] q;
		logic [63:0] res;
		logic [63:0] bitv;
		q = v;
		res = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (q >= res + bitv) begin
				q = q - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q1.30, entry 0 is 0.5
	typedef logic [16:0][Q30_W-1:0] pow_tab_t;

	function automatic pow_tab_t pow_tab();
		pow_tab_t t;
		logic [63:0] c;
		c = 64'd1 << 29;
		t[0] = c[Q30_W-1:0];
		for (int k = 1; k <= 16; k++) begin
			c = isqrt_c(c << 30);
			t[k] = c[Q30_W-1:0];
		end
		return t;
	endfunction

	localparam pow_tab_t POW_TAB = pow_tab();

endpackage

/* hw/rtl/bpls_front.sv */
module bpls_front import bpls_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [COORD_W-1:0] ray_x,
	input  logic [COORD_W-1:0] ray_y,
	input  logic [COORD_W-1:0] ray_z,
	input  logic [COORD_W-1:0] point_x,
	input  logic [COORD_W-1:0] point_y,
	input  logic [COORD_W-1:0] point_z,
	input  logic [COORD_W-1:0] normal_x,
	input  logic [COORD_W-1:0] normal_y,
	input  logic [COORD_W-1:0] normal_z,
	input  logic               last_light,
	input  logic               pop,
	output logic               item_valid,
	output item_t              item
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	item_t            cls;
	logic             push;

	// classify and pack the incoming transaction
	always_comb begin
		cls.kind   = kind_t'(op);
		cls.last   = last_light;
		cls.ray    = {ray_z, ray_y, ray_x};
		cls.point  = {point_z, point_y, point_x};
		cls.normal = {normal_z, normal_y, normal_x};
	end

	assign in_ready   = (cnt_q < CNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rp_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cls;
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < CNT_W'(QUEUE_DEPTH)) else $error("queue overrun");

endmodule

/* hw/rtl/bpls_sqrt.sv */
module bpls_sqrt import bpls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root,
	output unit_st_t          st
);
	logic [RAD_W-1:0] rem_q, res_q, bit_q, trial;
	logic [4:0]       cnt_q;
	logic             busy_q, done_q;

	assign trial = res_q + bit_q;
	assign root  = res_q[ROOT_W-1:0];
	assign st    = '{busy: busy_q, done: done_q};

	// iteration control, one result bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// digit-by-digit root
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rad;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

/* hw/rtl/bpls_div.sv */
module bpls_div import bpls_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    sat_mode,
	input  logic [FRAC_BITS+31:0]   num,
	input  logic [DEN_W-1:0]        den,
	output logic [QUO_W-1:0]        quo,
	output unit_st_t                st
);
	localparam int NUM_W  = FRAC_BITS + 32;
	localparam int UNIT_K = FRAC_BITS + 1;

	logic [DEN_W:0]   rem_q, trial;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] nl_q, quo_q;
	logic [5:0]       cnt_q;
	logic             busy_q, done_q;
	logic [NUM_W-1:0] hi_sat, hi_unit;
	logic             ovf;

	assign hi_sat  = num >> QUO_W;
	assign hi_unit = num >> UNIT_K;
	assign ovf     = sat_mode && (hi_sat[DEN_W:0] >= {1'b0, den});
	assign trial   = {rem_q[DEN_W-1:0], nl_q[QUO_W-1]};
	assign quo     = quo_q;
	assign st      = '{busy: busy_q, done: done_q};

	// iteration control; an overflowing ratio finishes at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf;
				done_q <= ovf;
				cnt_q  <= sat_mode ? 6'(QUO_W) : 6'(UNIT_K);
			end else if (busy_q) begin
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (sat_mode) begin
				rem_q <= hi_sat[DEN_W:0];
				nl_q  <= num[QUO_W-1:0];
				quo_q <= ovf ? '1 : '0;
			end else begin
				rem_q <= hi_unit[DEN_W:0];
				nl_q  <= QUO_W'(num[UNIT_K-1:0]) << (QUO_W - UNIT_K);
				quo_q <= '0;
			end
		end else if (busy_q) begin
			nl_q <= nl_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* hw/rtl/bpls_back.sv */
module bpls_back import bpls_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       item_valid,
	input  item_t      item,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	localparam int NV_W  = FRAC_BITS + 2;
	localparam int W_W   = FRAC_BITS + 1;
	localparam int NUM_W = FRAC_BITS + 32;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [Q30_W-1:0] ONE_Q30 = Q30_W'(1) << 30;

	state_t state_q, state_d;

	// surface and accumulator state
	logic signed [COORD_W-1:0] view_q [3];
	logic signed [COORD_W-1:0] hit_q [3];
	logic signed [COORD_W-1:0] norm_q [3];
	logic [SUM_W-1:0]          sum_q [3];

	// per-light working registers
	logic signed [VEC_W-1:0] vec_q [3];
	logic [MAG_W-1:0]        a_q [3];
	logic                    neg_q [3];
	logic [1:0]              s_q, idx_q;
	logic                    phase_q, dsel_q, last_q;
	logic signed [63:0]      acc_q;
	logic [ROOT_W-1:0]       r_q;
	logic signed [NV_W-1:0]  nv_q [3];
	logic signed [NV_W-1:0]  ln_q [3];
	logic [DEN_W-1:0]        d_q;
	logic [W_W-1:0]          wd_q, x_q;
	logic [Q30_W-1:0]        ws_q, m_q, pw_q;
	logic [4:0]              n_q, ip_q;
	logic [15:0]             f_q, fp_q;
	logic [3:0]              k_q;
	logic [QUO_W-1:0]        rd_q, rs_q;
	logic [MUL_W-1:0]        td_q;
	logic                    out_valid_q;
	logic [7:0]              red_q, green_q, blue_q;

	// shared multiplier
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p_q;

	// shared units
	logic              sqrt_start, div_start, div_sat;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [QUO_W-1:0]  div_quo;
	logic [ROOT_W-1:0] sqrt_root;
	unit_st_t          div_st, sqrt_st;

	// combinational helpers
	logic [VEC_W-1:0]        mag [3];
	logic [VEC_W-1:0]        mmax;
	logic [1:0]              s_new;
	logic signed [VEC_W-1:0] hv [3];
	logic                    h_zero;
	logic [63:0]             dsh;
	logic [W_W-1:0]          clampv;
	logic [31:0]             m2;
	logic [28:0]             tv;
	logic [NV_W-1:0]         qv;
	logic [SUM_W+1:0]        tot;
	logic [SUM_W:0]          cv [3];
	logic [32:0]             chv [3];
	logic                    out_load;

	bpls_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (acc_q[RAD_W-1:0]),
		.root   (sqrt_root),
		.st     (sqrt_st)
	);

	bpls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sat_mode (div_sat),
		.num      (div_num),
		.den      (div_den),
		.quo      (div_quo),
		.st       (div_st)
	);

	// magnitudes, prescale shift, half vector, clamp, product slices and channel sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec_q[i][VEC_W-1] ? VEC_W'(-vec_q[i]) : VEC_W'(vec_q[i]);
			hv[i]  = VEC_W'(ln_q[i]) - VEC_W'(view_q[i]);
		end
		mmax = mag[0];
		if (mag[1] > mmax) mmax = mag[1];
		if (mag[2] > mmax) mmax = mag[2];
		if (mmax < (VEC_W'(1) << 30))      s_new = 2'd0;
		else if (mmax < (VEC_W'(1) << 31)) s_new = 2'd1;
		else if (mmax < (VEC_W'(1) << 32)) s_new = 2'd2;
		else                               s_new = 2'd3;
		h_zero = (hv[0] == '0) && (hv[1] == '0) && (hv[2] == '0);
		dsh = 64'(acc_q) >> FRAC_BITS;
		if (acc_q <= 64'sd0)                       clampv = '0;
		else if (dsh > (64'd1 << FRAC_BITS))       clampv = W_W'(1) << FRAC_BITS;
		else                                       clampv = dsh[W_W-1:0];
		m2  = mul_p_q[30 +: 32];
		tv  = mul_p_q[8 +: 29];
		qv  = {1'b0, div_quo[W_W-1:0]};
		tot = (SUM_W+2)'(sum_q[idx_q]) + (SUM_W+2)'(td_q)
			+ (SUM_W+2)'(mul_p_q[16 +: MUL_W]);
		for (int i = 0; i < 3; i++) begin
			cv[i]  = (SUM_W+1)'(sum_q[i]) + (SUM_W+1)'(cfg.ambient[16*i +: 16]);
			chv[i] = cv[i][SUM_W:8];
		end
	end

	assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// next state, unit starts, multiplier operands
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		div_sat    = 1'b0;
		div_num    = NUM_W'(a_q[idx_q]) << FRAC_BITS;
		div_den    = DEN_W'(r_q);
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					pop = 1'b1;
					if (item.kind == KIND_LIGHT) state_d = S_UMAG;
					else if (item.last)          state_d = S_EMIT;
				end
			end
			S_UMAG: state_d = S_USQ;
			S_USQ: begin
				mul_a   = MUL_W'(a_q[idx_q]);
				mul_b   = MUL_W'(a_q[idx_q]);
				state_d = S_UACC;
			end
			S_UACC: state_d = (idx_q == 2'd2) ? S_USQRT_GO : S_USQ;
			S_USQRT_GO: begin
				sqrt_start = 1'b1;
				state_d    = S_USQRT;
			end
			S_USQRT: begin
				if (sqrt_st.done) state_d = (sqrt_root == '0) ? S_SAT : S_UDIV_GO;
			end
			S_UDIV_GO: begin
				div_start = 1'b1;
				state_d   = S_UDIV;
			end
			S_UDIV: begin
				if (div_st.done) state_d = (idx_q == 2'd2) ? S_UDONE : S_UDIV_GO;
			end
			S_UDONE: state_d = S_DOTM;
			S_DOTM: begin
				mul_a   = MUL_W'(norm_q[idx_q]);
				mul_b   = MUL_W'(nv_q[idx_q]);
				state_d = S_DOTA;
			end
			S_DOTA: state_d = (idx_q == 2'd2) ? S_DCLAMP : S_DOTM;
			S_DCLAMP: state_d = dsel_q ? S_POW0 : S_HVEC;
			S_HVEC: state_d = h_zero ? S_DOTM : S_UMAG;
			S_POW0: begin
				if (cfg.shine == '0 || x_q == '0) state_d = S_RDGO;
				else                              state_d = S_PNORM;
			end
			S_PNORM: if (m_q >= ONE_Q30) state_d = S_PSQM;
			S_PSQM: begin
				mul_a   = MUL_W'(m_q);
				mul_b   = MUL_W'(m_q);
				state_d = S_PSQA;
			end
			S_PSQA: state_d = (k_q == '0) ? S_PTM : S_PSQM;
			S_PTM: begin
				mul_a   = MUL_W'({n_q, 16'd0} - 21'(f_q));
				mul_b   = MUL_W'(cfg.shine);
				state_d = S_PTA;
			end
			S_PTA: state_d = (tv[28:16] >= 13'd31) ? S_RDGO : S_PEXM;
			S_PEXM: begin
				mul_a = MUL_W'(pw_q);
				mul_b = MUL_W'(POW_TAB[5'd16 - 5'(k_q)]);
				if (fp_q[k_q])         state_d = S_PEXA;
				else if (k_q == '0)    state_d = S_PFIN;
			end
			S_PEXA: state_d = (k_q == '0) ? S_PFIN : S_PEXM;
			S_PFIN: state_d = S_RDGO;
			S_RDGO: begin
				div_start = 1'b1;
				div_sat   = 1'b1;
				div_num   = NUM_W'(cfg.dpower) << FRAC_BITS;
				div_den   = d_q;
				state_d   = S_RDW;
			end
			S_RDW: if (div_st.done) state_d = S_RSGO;
			S_RSGO: begin
				div_start = 1'b1;
				div_sat   = 1'b1;
				div_num   = NUM_W'(cfg.shine) << (FRAC_BITS + 8);
				div_den   = d_q;
				state_d   = S_RSW;
			end
			S_RSW: if (div_st.done) state_d = S_TM1;
			S_TM1: begin
				mul_a   = MUL_W'(rd_q);
				mul_b   = MUL_W'(wd_q);
				state_d = S_TM2;
			end
			S_TM2: begin
				mul_a   = mul_p_q[FRAC_BITS +: MUL_W];
				mul_b   = MUL_W'(cfg.diffuse[16*idx_q +: 16]);
				state_d = S_TM3;
			end
			S_TM3: begin
				mul_a   = MUL_W'(rs_q);
				mul_b   = MUL_W'(ws_q);
				state_d = S_TM4;
			end
			S_TM4: begin
				mul_a   = mul_p_q[30 +: MUL_W];
				mul_b   = MUL_W'(cfg.specular[16*idx_q +: 16]);
				state_d = S_TM5;
			end
			S_TM5: begin
				if (idx_q != 2'd2) state_d = S_TM1;
				else               state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_SAT: state_d = last_q ? S_EMIT : S_IDLE;
			S_EMIT: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state register, model state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				view_q[i] <= '0;
				hit_q[i]  <= '0;
				norm_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load)      out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (state_q == S_IDLE && item_valid && item.kind == KIND_SURFACE) begin
				for (int i = 0; i < 3; i++) begin
					view_q[i] <= $signed(item.ray[i]);
					hit_q[i]  <= $signed(item.point[i]);
					norm_q[i] <= $signed(item.normal[i]);
					sum_q[i]  <= '0;
				end
			end
			if (state_q == S_SAT) begin
				for (int i = 0; i < 3; i++) sum_q[i] <= SUM_MAX;
			end
			if (state_q == S_TM5) begin
				sum_q[idx_q] <= (tot > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : tot[SUM_W-1:0];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (out_load) begin
			red_q   <= (chv[0] > 33'd255) ? 8'hFF : chv[0][7:0];
			green_q <= (chv[1] > 33'd255) ? 8'hFF : chv[1][7:0];
			blue_q  <= (chv[2] > 33'd255) ? 8'hFF : chv[2][7:0];
		end
		case (state_q)
			S_IDLE: begin
				last_q  <= item.last;
				phase_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					vec_q[i] <= VEC_W'($signed(item.point[i])) - VEC_W'(hit_q[i]);
				end
			end
			S_UMAG: begin
				s_q   <= s_new;
				idx_q <= '0;
				acc_q <= '0;
				for (int i = 0; i < 3; i++) begin
					a_q[i]   <= MAG_W'(mag[i] >> s_new);
					neg_q[i] <= vec_q[i][VEC_W-1];
				end
			end
			S_UACC: begin
				acc_q <= acc_q + 64'(mul_p_q);
				if (idx_q != 2'd2) idx_q <= idx_q + 1'b1;
			end
			S_USQRT: begin
				r_q   <= sqrt_root;
				idx_q <= '0;
			end
			S_UDIV: begin
				if (div_st.done) begin
					nv_q[idx_q] <= neg_q[idx_q] ? -$signed(qv) : $signed(qv);
					if (idx_q != 2'd2) idx_q <= idx_q + 1'b1;
				end
			end
			S_UDONE: begin
				acc_q  <= '0;
				idx_q  <= '0;
				dsel_q <= phase_q;
				if (!phase_q) begin
					d_q <= DEN_W'(r_q) << s_q;
					for (int i = 0; i < 3; i++) ln_q[i] <= nv_q[i];
				end
			end
			S_DOTA: begin
				acc_q <= acc_q + 64'(mul_p_q);
				if (idx_q != 2'd2) idx_q <= idx_q + 1'b1;
			end
			S_DCLAMP: begin
				if (dsel_q) x_q <= clampv;
				else        wd_q <= clampv;
			end
			S_HVEC: begin
				// a zero half vector keeps the light direction, still held in nv
				acc_q   <= '0;
				idx_q   <= '0;
				dsel_q  <= 1'b1;
				phase_q <= 1'b1;
				for (int i = 0; i < 3; i++) vec_q[i] <= hv[i];
			end
			S_POW0: begin
				if (cfg.shine == '0) ws_q <= ONE_Q30;
				else if (x_q == '0)  ws_q <= '0;
				m_q <= Q30_W'(x_q) << (30 - FRAC_BITS);
				n_q <= '0;
				f_q <= '0;
				k_q <= 4'd15;
			end
			S_PNORM: begin
				if (m_q < ONE_Q30) begin
					m_q <= m_q << 1;
					n_q <= n_q + 1'b1;
				end
			end
			S_PSQA: begin
				if (m2[31]) begin
					m_q      <= m2[31:1];
					f_q[k_q] <= 1'b1;
				end else begin
					m_q <= m2[Q30_W-1:0];
				end
				k_q <= k_q - 1'b1;
			end
			S_PTA: begin
				if (tv[28:16] >= 13'd31) ws_q <= '0;
				ip_q <= tv[20:16];
				fp_q <= tv[15:0];
				pw_q <= ONE_Q30;
				k_q  <= 4'd15;
			end
			S_PEXM: begin
				if (!fp_q[k_q] && k_q != '0) k_q <= k_q - 1'b1;
			end
			S_PEXA: begin
				pw_q <= mul_p_q[30 +: Q30_W];
				if (k_q != '0) k_q <= k_q - 1'b1;
			end
			S_PFIN: ws_q <= pw_q >> ip_q;
			S_RDW: if (div_st.done) rd_q <= div_quo;
			S_RSW: begin
				rs_q  <= div_quo;
				idx_q <= '0;
			end
			S_TM3: td_q <= mul_p_q[16 +: MUL_W];
			S_TM5: if (idx_q != 2'd2) idx_q <= idx_q + 1'b1;
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_st.busy) else $error("square root restarted while busy");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy) else $error("divider restarted while busy");

endmodule

/* hw/rtl/blinn_phong_point_light_shader.sv */
// Surface transaction: loads the surface state, and emits a colour when marked last.
// Light transaction: uses the shared iterative divider (up to 8 divisions, one quotient bit
// a cycle) and square root unit (up to 2 roots, 31 result bits each).
// One transaction is processed at a time; a two-entry queue accepts input meanwhile.
// Reset (arst_n low, asynchronous) clears queue, surface state and accumulator, and loads
// the config defaults.
module blinn_phong_point_light_shader import bpls_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [COORD_W-1:0]    ray_x,
	input  logic [COORD_W-1:0]    ray_y,
	input  logic [COORD_W-1:0]    ray_z,
	input  logic [COORD_W-1:0]    point_x,
	input  logic [COORD_W-1:0]    point_y,
	input  logic [COORD_W-1:0]    point_z,
	input  logic [COORD_W-1:0]    normal_x,
	input  logic [COORD_W-1:0]    normal_y,
	input  logic [COORD_W-1:0]    normal_z,
	input  logic                  last_light,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t  cfg_q;
	item_t item;
	logic  item_valid, pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ambient  <= '0;
			cfg_q.diffuse  <= '0;
			cfg_q.specular <= '0;
			cfg_q.dpower   <= DPOWER_RST;
			cfg_q.shine    <= SHINE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_AMBIENT:  cfg_q.ambient  <= cfg_data;
				REG_DIFFUSE:  cfg_q.diffuse  <= cfg_data;
				REG_SPECULAR: cfg_q.specular <= cfg_data;
				REG_DPOWER:   cfg_q.dpower   <= cfg_data[DPOWER_W-1:0];
				REG_SHINE:    cfg_q.shine    <= cfg_data[SHINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bpls_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.ray_x      (ray_x),
		.ray_y      (ray_y),
		.ray_z      (ray_z),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z),
		.last_light (last_light),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	bpls_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

endmodule
